FILE: rtl/csmv_pkg.sv
// Shared types and constants for the half-precision sparse matrix-vector unit.
package csmv_pkg;

  localparam int ROWS_DEF = 16;
  localparam int COLS_DEF = 16;
  localparam int WW       = 81;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_NZ   = 2'd1,
    OP_FIN  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [5:0]  row;
    logic [5:0]  column;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic [5:0]  out_row;
    logic [15:0] sum;
    logic        last;
  } out_t;

endpackage

FILE: rtl/csr_sparse_matvec_fp16.sv
// Top level: half-precision sparse matrix-vector multiply with one shared multiply-add unit.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_ready  | csmv_pkg::in_t  (operation, row, column, value)
//   out     | output    | out_valid / out_ready| csmv_pkg::out_t (out_row, sum, last)
//
// Load and ignored items are taken in S_IDLE. A nonzero steps through multiply, align,
// add, a normalize loop on the 81-bit sum, single then half rounding.
// A finish steps through E_RD, E_LD and E_SEND for each row, one accumulator read per row.
// Reset clears control state and the accumulator valid bits; the vector store is not cleared.
// in_ready is high only while the sequencer is idle; out stalls hold the current row beat.
module csr_sparse_matvec_fp16 #(
  parameter int ROWS = csmv_pkg::ROWS_DEF,
  parameter int COLS = csmv_pkg::COLS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  csmv_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output csmv_pkg::out_t  out_data
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int WW = csmv_pkg::WW;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ALIGN, S_ADD, S_NORM, S_ROUND, S_PACK, E_RD, E_LD, E_SEND
  } state_t;

  state_t state_r;

  logic [15:0] vec_mem [COLS];
  logic [15:0] acc_mem [ROWS];
  logic [ROWS-1:0] acc_ok_r;

  logic [15:0] vq_r, accq_r, val_r;
  logic        accv_r;
  logic [RW-1:0] row_r, cnt_r, rd_addr;

  logic [21:0] pm_r;
  logic [5:0]  psh_r, ash_r;
  logic [10:0] am_r;
  logic        ps_r, as_r, nan_r, inf_r, infs_r, zero_r, sgn_r;
  logic [WW-1:0] pw_r, aw_r, w_r;
  logic [6:0]  sh_r;
  logic [23:0] m24_r;
  logic signed [7:0] e_r;

  logic        out_valid_r;
  csmv_pkg::out_t out_data_r;

  logic acc_wr;
  logic [15:0] acc_wdata;

  // operand decode
  logic [15:0] acc_in;
  logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, c_nan, c_inf;
  logic p_nan, p_inf, p_s;
  logic [4:0] ea, eb, ec;

  always_comb begin
    acc_in = accv_r ? accq_r : 16'h0000;
    ea = (val_r[14:10] == 5'd0) ? 5'd1 : val_r[14:10];
    eb = (vq_r[14:10] == 5'd0) ? 5'd1 : vq_r[14:10];
    ec = (acc_in[14:10] == 5'd0) ? 5'd1 : acc_in[14:10];
    a_nan = (val_r[14:10] == 5'h1F) && (val_r[9:0] != 10'd0);
    a_inf = (val_r[14:10] == 5'h1F) && (val_r[9:0] == 10'd0);
    a_zero = (val_r[14:0] == 15'd0);
    b_nan = (vq_r[14:10] == 5'h1F) && (vq_r[9:0] != 10'd0);
    b_inf = (vq_r[14:10] == 5'h1F) && (vq_r[9:0] == 10'd0);
    b_zero = (vq_r[14:0] == 15'd0);
    c_nan = (acc_in[14:10] == 5'h1F) && (acc_in[9:0] != 10'd0);
    c_inf = (acc_in[14:10] == 5'h1F) && (acc_in[9:0] == 10'd0);
    p_s = val_r[15] ^ vq_r[15];
    p_nan = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    p_inf = (a_inf || b_inf) && !p_nan;
  end

  // single rounding
  logic [24:0] m25;
  logic        rup;
  always_comb begin
    rup = w_r[WW-25] && ((|w_r[WW-26:0]) || w_r[WW-24]);
    m25 = {1'b0, w_r[WW-1:WW-24]} + {24'd0, rup};
  end

  // half packing
  logic [15:0] h_res;
  logic        nrm;
  logic signed [7:0] negm1;
  logic [5:0]  s_amt;
  logic [25:0] mq, rem, hlf, msk;
  logic        hrnd;
  logic [14:0] base;
  always_comb begin
    negm1 = -e_r - 8'sd1;
    nrm = (e_r >= -8'sd14);
    if (nrm) begin
      s_amt = 6'd13;
    end else if (negm1 > 8'sd25) begin
      s_amt = 6'd25;
    end else begin
      s_amt = negm1[5:0];
    end
    mq = {2'b00, m24_r} >> s_amt;
    msk = (26'd1 << s_amt) - 26'd1;
    rem = {2'b00, m24_r} & msk;
    hlf = 26'd1 << (s_amt - 6'd1);
    hrnd = (rem > hlf) || ((rem == hlf) && mq[0]);
    base = nrm ? {5'(e_r + 8'sd14), 10'd0} : 15'd0;
    if (nan_r) begin
      h_res = 16'h7E00;
    end else if (inf_r) begin
      h_res = {infs_r, 15'h7C00};
    end else if (zero_r) begin
      h_res = {sgn_r, 15'd0};
    end else if (e_r >= 8'sd16) begin
      h_res = {sgn_r, 15'h7C00};
    end else begin
      h_res = {sgn_r, base + mq[14:0] + {14'd0, hrnd}};
    end
  end

  assign acc_wr = (state_r == S_PACK);
  assign acc_wdata = h_res;
  assign rd_addr = (state_r == S_IDLE) ? in_data.row[RW-1:0] : cnt_r;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && (in_data.operation == csmv_pkg::OP_LOAD) &&
        ({1'b0, in_data.row} < 7'(COLS))) begin
      vec_mem[in_data.row[CW-1:0]] <= in_data.value;
    end
    vq_r <= vec_mem[in_data.column[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (acc_wr) begin
      acc_mem[row_r] <= acc_wdata;
    end
    accq_r <= acc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_ok_r <= '0;
      accv_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      accv_r <= acc_ok_r[rd_addr];
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            val_r <= in_data.value;
            row_r <= in_data.row[RW-1:0];
            cnt_r <= '0;
            if ((in_data.operation == csmv_pkg::OP_NZ) &&
                ({1'b0, in_data.row} < 7'(ROWS)) &&
                ({1'b0, in_data.column} < 7'(COLS))) begin
              state_r <= S_MUL;
            end else if (in_data.operation == csmv_pkg::OP_FIN) begin
              state_r <= E_RD;
            end
          end
        end
        S_MUL: begin
          pm_r <= 22'({val_r[14:10] != 5'd0, val_r[9:0]}) *
                  22'({vq_r[14:10] != 5'd0, vq_r[9:0]});
          psh_r <= 6'(ea) + 6'(eb) - 6'd2;
          am_r <= {acc_in[14:10] != 5'd0, acc_in[9:0]};
          ash_r <= 6'(ec) + 6'd23;
          ps_r <= p_s;
          as_r <= acc_in[15];
          nan_r <= p_nan || c_nan || (p_inf && c_inf && (p_s != acc_in[15]));
          inf_r <= p_inf || c_inf;
          infs_r <= p_inf ? p_s : acc_in[15];
          state_r <= S_ALIGN;
        end
        S_ALIGN: begin
          pw_r <= {{(WW-22){1'b0}}, pm_r} << psh_r;
          aw_r <= {{(WW-11){1'b0}}, am_r} << ash_r;
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (ps_r == as_r) begin
            w_r <= pw_r + aw_r;
            sgn_r <= ps_r;
            zero_r <= (pw_r == '0) && (aw_r == '0);
          end else if (pw_r >= aw_r) begin
            w_r <= pw_r - aw_r;
            sgn_r <= (pw_r == aw_r) ? 1'b0 : ps_r;
            zero_r <= (pw_r == aw_r);
          end else begin
            w_r <= aw_r - pw_r;
            sgn_r <= as_r;
            zero_r <= 1'b0;
          end
          sh_r <= '0;
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (nan_r || inf_r || zero_r) begin
            state_r <= S_PACK;
          end else if (w_r[WW-1:WW-8] == 8'd0) begin
            w_r <= w_r << 8;
            sh_r <= sh_r + 7'd8;
          end else if (!w_r[WW-1]) begin
            w_r <= w_r << 1;
            sh_r <= sh_r + 7'd1;
          end else begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          m24_r <= m25[24] ? 24'h800000 : m25[23:0];
          e_r <= 8'sd32 - $signed({1'b0, sh_r}) + $signed({7'd0, m25[24]});
          state_r <= S_PACK;
        end
        S_PACK: begin
          acc_ok_r[row_r] <= 1'b1;
          state_r <= S_IDLE;
        end
        E_RD: begin
          state_r <= E_LD;
        end
        E_LD: begin
          out_data_r.out_row <= 6'(cnt_r);
          out_data_r.sum <= accv_r ? accq_r : 16'h0000;
          out_data_r.last <= (cnt_r == RW'(ROWS - 1));
          out_valid_r <= 1'b1;
          acc_ok_r[cnt_r] <= 1'b0;
          state_r <= E_SEND;
        end
        E_SEND: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (cnt_r == RW'(ROWS - 1)) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + 1'b1;
              state_r <= E_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
